[rtl/dewp_pkg.sv]
// ----------------------------------------------------------------------------
// dewp_pkg
// Shared types, constants and helpers of the digitizer event word packer.
// ----------------------------------------------------------------------------
package dewp_pkg;

	localparam int CHANNELS_DEF    = 8;
	localparam int MAX_PAIRS_DEF   = 4096;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int MASK_W   = 8;
	localparam int TS_W     = 48;
	localparam int PAIRS_W  = 13;
	localparam int SAMPLE_W = 16;
	localparam int CLAMP_W  = 14;
	localparam int CHL_W    = 4;
	localparam int PERIOD_W = 8;
	localparam int WORD_W   = 32;
	localparam int STAMP_W  = 31;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd10;
	localparam logic [WORD_W-1:0]   TAG_WORDS    = 32'hA000_0000;

	localparam logic OP_START = 1'b0;
	localparam logic OP_PAIR  = 1'b1;

	typedef struct packed {
		logic                       operation;
		logic [MASK_W-1:0]          channel_mask;
		logic [TS_W-1:0]            timestamp_ns;
		logic [PAIRS_W-1:0]         pairs_per_channel;
		logic signed [SAMPLE_W-1:0] sample_first;
		logic signed [SAMPLE_W-1:0] sample_second;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              run_last;
		logic              event_last;
	} out_item_t;

	// start: main = tagged word count, aux = event count
	// pair:  main = data word, aux = channel size word
	typedef struct packed {
		logic              is_start;
		logic              first;
		logic              ev_last;
		logic [MASK_W-1:0] mask;
		logic [TS_W-1:0]   ts;
		logic [WORD_W-1:0] main_word;
		logic [WORD_W-1:0] aux_word;
	} cmd_t;

	function automatic logic [CLAMP_W-1:0] clamp_sample(logic signed [SAMPLE_W-1:0] s);
		logic [CLAMP_W-1:0] r;
		r = s[SAMPLE_W-1] ? '0 : s[CLAMP_W-1:0];
		return r;
	endfunction

endpackage

[rtl/dewp_queue.sv]
// ----------------------------------------------------------------------------
// dewp_queue
// Small register queue of decoded commands between front and back.
// ----------------------------------------------------------------------------
module dewp_queue #(
	parameter int DEPTH = dewp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dewp_pkg::cmd_t din,
	output logic           full,
	input  logic           pop,
	output dewp_pkg::cmd_t dout,
	output logic           valid
);
	import dewp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;

	assign full  = (count_q == (AW+1)'(DEPTH));
	assign valid = (count_q != '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/dewp_front.sv]
// ----------------------------------------------------------------------------
// dewp_front
// Accepts items, tracks event progress and queues decoded commands.
// ----------------------------------------------------------------------------
module dewp_front #(
	parameter int CHANNELS  = dewp_pkg::CHANNELS_DEF,
	parameter int MAX_PAIRS = dewp_pkg::MAX_PAIRS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dewp_pkg::in_item_t in_item,
	input  logic               q_full,
	output logic               push,
	output dewp_pkg::cmd_t     cmd
);
	import dewp_pkg::*;

	logic [WORD_W-1:0]  event_count_q;
	logic               event_open_q;
	logic [CHL_W-1:0]   channels_left_q;
	logic [PAIRS_W-1:0] pairs_left_q;
	logic [PAIRS_W-1:0] pairs_each_q;

	logic               accept;
	logic [CHL_W-1:0]   n_chan;
	logic [PAIRS_W-1:0] pairs_sat;
	logic [17:0]        total;
	logic [WORD_W-1:0]  count_next;
	logic               first;
	logic [PAIRS_W-1:0] pl_next;
	logic [CHL_W-1:0]   cl_next;
	logic               chan_done;
	logic               ev_done;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && ((in_item.operation == OP_START) || event_open_q);

	always_comb begin
		n_chan = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			n_chan = n_chan + CHL_W'(in_item.channel_mask[i]);
		end
		pairs_sat = in_item.pairs_per_channel;
		if (pairs_sat == '0) begin
			pairs_sat = PAIRS_W'(1);
		end else if ({19'd0, pairs_sat} > 32'(MAX_PAIRS)) begin
			pairs_sat = PAIRS_W'(MAX_PAIRS);
		end
		total      = 18'(n_chan) * 18'({1'b0, pairs_sat} + 14'd2) + 18'd4;
		count_next = event_count_q + 1'b1;

		first     = (pairs_left_q == pairs_each_q);
		pl_next   = pairs_left_q - 1'b1;
		cl_next   = channels_left_q - 1'b1;
		chan_done = (pl_next == '0);
		ev_done   = chan_done && (cl_next == '0);

		cmd = '0;
		if (in_item.operation == OP_START) begin
			cmd.is_start  = 1'b1;
			cmd.ev_last   = (n_chan == '0);
			cmd.mask      = in_item.channel_mask;
			cmd.ts        = in_item.timestamp_ns;
			cmd.main_word = TAG_WORDS | WORD_W'(total);
			cmd.aux_word  = count_next;
		end else begin
			cmd.first     = first;
			cmd.ev_last   = ev_done;
			cmd.main_word = {2'b00, clamp_sample(in_item.sample_second),
				2'b00, clamp_sample(in_item.sample_first)};
			cmd.aux_word  = WORD_W'(pairs_each_q) + 32'd2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_count_q   <= '0;
			event_open_q    <= 1'b0;
			channels_left_q <= '0;
			pairs_left_q    <= '0;
			pairs_each_q    <= '0;
		end else if (accept) begin
			if (in_item.operation == OP_START) begin
				event_count_q <= count_next;
				if (n_chan != '0) begin
					event_open_q    <= 1'b1;
					channels_left_q <= n_chan;
					pairs_left_q    <= pairs_sat;
					pairs_each_q    <= pairs_sat;
				end else begin
					event_open_q    <= 1'b0;
					channels_left_q <= '0;
					pairs_left_q    <= '0;
					pairs_each_q    <= '0;
				end
			end else if (event_open_q) begin
				pairs_left_q <= pl_next;
				if (chan_done) begin
					channels_left_q <= cl_next;
					if (cl_next == '0) begin
						event_open_q <= 1'b0;
					end else begin
						pairs_left_q <= pairs_each_q;
					end
				end
			end
		end
	end

endmodule

[rtl/dewp_div.sv]
// ----------------------------------------------------------------------------
// dewp_div
// Bit-serial restoring divider turning nanoseconds into clock ticks.
// ----------------------------------------------------------------------------
module dewp_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [dewp_pkg::TS_W-1:0]      dividend,
	input  logic [dewp_pkg::PERIOD_W-1:0]  divisor,
	output logic                           done,
	output logic [dewp_pkg::STAMP_W-1:0]   quotient
);
	import dewp_pkg::*;

	localparam int CW = $clog2(TS_W);

	logic                busy_q;
	logic                done_q;
	logic [CW-1:0]       cnt_q;
	logic [TS_W-1:0]     quo_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W-1:0] dvs_q;

	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W:0]   diff;
	logic                ge;

	assign trial    = {rem_q, quo_q[TS_W-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign ge       = (trial >= {1'b0, dvs_q});
	assign done     = done_q;
	assign quotient = quo_q[STAMP_W-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[TS_W-2:0], ge};
			rem_q <= ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(TS_W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

[rtl/dewp_back.sv]
// ----------------------------------------------------------------------------
// dewp_back
// Executes queued commands and emits readout words through an output register.
// ----------------------------------------------------------------------------
module dewp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dewp_pkg::PERIOD_W-1:0] period,
	input  dewp_pkg::cmd_t                head,
	input  logic                          head_valid,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output dewp_pkg::out_item_t           out_item
);
	import dewp_pkg::*;

	cmd_t               cur_q;
	logic               cur_valid_q;
	logic [1:0]         idx_q;
	logic               stamp_ok_q;
	logic [STAMP_W-1:0] stamp_q;
	out_item_t          out_item_q;
	logic               out_valid_q;

	logic [PERIOD_W-1:0] divisor;
	logic                div_start;
	logic                div_done;
	logic [STAMP_W-1:0]  div_quo;
	logic [1:0]          pos;
	logic [WORD_W-1:0]   word;
	logic                last;
	logic                go;

	assign divisor = (period == '0) ? PERIOD_W'(1) : period;

	dewp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (head.ts),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		pos = (cur_q.is_start || cur_q.first) ? idx_q : 2'd2;
		if (cur_q.is_start) begin
			case (idx_q)
				2'd0: word = cur_q.main_word;
				2'd1: word = WORD_W'(cur_q.mask);
				2'd2: word = cur_q.aux_word;
				default: word = WORD_W'(stamp_q);
			endcase
			last = (idx_q == 2'd3);
		end else begin
			case (pos)
				2'd0: word = cur_q.aux_word;
				2'd1: word = WORD_W'(stamp_q);
				default: word = cur_q.main_word;
			endcase
			last = (pos == 2'd2);
		end
	end

	assign go = cur_valid_q && (!cur_q.is_start || stamp_ok_q) && (!out_valid_q || out_ready);
	assign pop       = head_valid && (!cur_valid_q || (go && last));
	assign div_start = pop && head.is_start;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (go) begin
			out_item_q.word       <= word;
			out_item_q.run_last   <= last;
			out_item_q.event_last <= last && cur_q.ev_last;
		end
		if (div_done) begin
			stamp_q <= div_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			stamp_ok_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (go && last) begin
				cur_valid_q <= 1'b0;
			end
			if (go) begin
				idx_q <= last ? 2'd0 : idx_q + 1'b1;
			end
			if (div_start) begin
				stamp_ok_q <= 1'b0;
			end else if (div_done) begin
				stamp_ok_q <= 1'b1;
			end
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/digitizer_event_word_packer.sv]
// ----------------------------------------------------------------------------
// digitizer_event_word_packer
// Packs event headers and digitizer sample pairs into 32-bit readout words.
//
// Input channel (in_valid/in_ready/in_item): start items and sample pairs.
// Output channel (out_valid/out_ready/out_item): one readout word per item,
// with run_last on the last word of an input item and event_last on the
// last word of an event. Config channel (cfg_valid/cfg_ready/cfg_data)
// writes the clock period; it is always ready.
// A front stage decodes items into a command queue; the back stage turns
// each command into one to four words through a registered output.
// Sample pairs flow at one per cycle while out_ready is high; a channel's
// first pair yields three words. A start item holds the back stage while it
// loads and runs the bit-serial timestamp divider, then emits four header
// words. Pairs pass the queue, the command register and the output register.
// While the back stage works or the receiver stalls, the queue absorbs
// items and in_ready drops only when it is full.
// Reset clears the event counter and event state and sets the period to 10.
// ----------------------------------------------------------------------------
module digitizer_event_word_packer #(
	parameter int CHANNELS    = dewp_pkg::CHANNELS_DEF,
	parameter int MAX_PAIRS   = dewp_pkg::MAX_PAIRS_DEF,
	parameter int QUEUE_DEPTH = dewp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dewp_pkg::PERIOD_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  dewp_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output dewp_pkg::out_item_t           out_item
);
	import dewp_pkg::*;

	logic [PERIOD_W-1:0] clock_period_q;
	logic                q_push;
	logic                q_full;
	logic                q_pop;
	logic                q_valid;
	cmd_t                q_din;
	cmd_t                q_dout;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_period_q <= PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			clock_period_q <= cfg_data;
		end
	end

	dewp_front #(
		.CHANNELS  (CHANNELS),
		.MAX_PAIRS (MAX_PAIRS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_full   (q_full),
		.push     (q_push),
		.cmd      (q_din)
	);

	dewp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.valid  (q_valid)
	);

	dewp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.period     (clock_period_q),
		.head       (q_dout),
		.head_valid (q_valid),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

`ifndef SYNTHESIS
	// the event closes only on the last word of an item
	a_event_last_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.event_last |-> out_item.run_last)
		else $error("event_last without run_last");

	// a full queue always offers a command to the back stage
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> q_valid)
		else $error("queue full but empty head");

	// a command is never popped from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");
`endif

endmodule
